// ===== rtl/salsa_pkg.sv =====
// ----------------------------------------------------------------------------
// salsa_pkg
// Shared types, constants and helper functions of the Salsa20 stream XOR unit.
// ----------------------------------------------------------------------------
package salsa_pkg;

    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 64;
    localparam int REG_COUNT   = 5;
    localparam int POS_W       = 64;
    localparam int OFS_W       = 6;
    localparam int BLK_W       = POS_W - OFS_W;
    localparam int WORDS       = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic [2:0] {
        REG_KEY0  = 3'd0,
        REG_KEY1  = 3'd1,
        REG_KEY2  = 3'd2,
        REG_KEY3  = 3'd3,
        REG_NONCE = 3'd4
    } reg_idx_t;

    typedef logic [WORDS-1:0][31:0] word_array_t;
    typedef logic [3:0][63:0]       key_t;

    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        logic [OFS_W-1:0] offset;
        logic [BLK_W-1:0] blk_idx;
        logic             new_blk;
    } queue_entry_t;

    typedef struct packed {
        logic             start;
        logic [BLK_W-1:0] blk_idx;
    } core_req_t;

    localparam logic [31:0] SIGMA [4] = '{
        32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
    };

    // word indexes (a, b, c, d) of the four quarter rounds, column half then row half
    localparam logic [3:0] QR_IDX [2][4][4] = '{
        '{
            '{4'd0,  4'd4,  4'd8,  4'd12},
            '{4'd5,  4'd9,  4'd13, 4'd1 },
            '{4'd10, 4'd14, 4'd2,  4'd6 },
            '{4'd15, 4'd3,  4'd7,  4'd11}
        },
        '{
            '{4'd0,  4'd1,  4'd2,  4'd3 },
            '{4'd5,  4'd6,  4'd7,  4'd4 },
            '{4'd10, 4'd11, 4'd8,  4'd9 },
            '{4'd15, 4'd12, 4'd13, 4'd14}
        }
    };

    function automatic logic [31:0] rotl_step(logic [31:0] v, logic [1:0] step);
        logic [31:0] r;
        case (step)
            2'd0:    r = {v[24:0], v[31:25]};
            2'd1:    r = {v[22:0], v[31:23]};
            2'd2:    r = {v[18:0], v[31:19]};
            default: r = {v[13:0], v[31:14]};
        endcase
        return r;
    endfunction

    function automatic word_array_t make_init(key_t key, logic [63:0] nonce,
                                              logic [BLK_W-1:0] blk);
        word_array_t w;
        logic [63:0] idx;
        idx   = {{(64-BLK_W){1'b0}}, blk};
        w[0]  = SIGMA[0];
        w[1]  = key[0][31:0];
        w[2]  = key[0][63:32];
        w[3]  = key[1][31:0];
        w[4]  = key[1][63:32];
        w[5]  = SIGMA[1];
        w[6]  = nonce[31:0];
        w[7]  = nonce[63:32];
        w[8]  = idx[31:0];
        w[9]  = idx[63:32];
        w[10] = SIGMA[2];
        w[11] = key[2][31:0];
        w[12] = key[2][63:32];
        w[13] = key[3][31:0];
        w[14] = key[3][63:32];
        w[15] = SIGMA[3];
        return w;
    endfunction

endpackage

// ===== rtl/salsa20_stream_xor_unit.sv =====
// ----------------------------------------------------------------------------
// salsa20_stream_xor_unit
// Salsa20 stream cipher, 256-bit key, 64-bit nonce, one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Program key_part_0..3 and nonce_value over the APB port (64-bit data,
//   register i at byte address 8*i) while no byte is in flight.
//   Send bytes on data_valid/data_ready with last_byte marking the end of a
//   message; each byte comes back XORed with its keystream byte on
//   result_valid/result_ready, result_last copying last_byte.
//   A byte inside a keystream block passes through the queue and then the
//   result register on its way to result_valid.
//   Throughput is one byte per cycle inside a block while result_ready
//   stays high. The first byte of each 64-byte block waits while the
//   block core builds its keystream block, one quarter-round line per cycle.
//   A byte with last_byte set returns the position to zero, so the next
//   byte starts keystream block 0 again.
//   Reset clears the registers, the byte position and the queue.
//   When the receiver stalls, the result register holds and the queue of
//   four bytes fills; data_ready then drops until space frees.
// ----------------------------------------------------------------------------
module salsa20_stream_xor_unit
    import salsa_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              data_valid,
    output logic              data_ready,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [7:0]        result_byte,
    output logic              result_last
);

    key_t         key_reg;
    logic [63:0]  nonce_reg;
    reg_idx_t     reg_idx;
    logic         reg_write;
    queue_entry_t push_entry;
    queue_entry_t head;
    logic         q_push;
    logic         q_pop;
    logic         q_full;
    logic         q_empty;
    core_req_t    req;
    logic         core_done;
    word_array_t  ks_words;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign reg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_idx)
            REG_KEY0:  prdata = key_reg[0];
            REG_KEY1:  prdata = key_reg[1];
            REG_KEY2:  prdata = key_reg[2];
            REG_KEY3:  prdata = key_reg[3];
            REG_NONCE: prdata = nonce_reg;
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            nonce_reg <= '0;
        end
        else if (reg_write)
        begin
            unique case (reg_idx)
                REG_KEY0:  key_reg[0] <= pwdata;
                REG_KEY1:  key_reg[1] <= pwdata;
                REG_KEY2:  key_reg[2] <= pwdata;
                REG_KEY3:  key_reg[3] <= pwdata;
                REG_NONCE: nonce_reg  <= pwdata;
                default:   ;
            endcase
        end
    end

    salsa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_ready (data_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (push_entry)
    );

    salsa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (head),
        .full       (q_full),
        .empty      (q_empty)
    );

    salsa_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .key      (key_reg),
        .nonce    (nonce_reg),
        .req      (req),
        .done     (core_done),
        .ks_words (ks_words)
    );

    salsa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .req          (req),
        .core_done    (core_done),
        .ks_words     (ks_words),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_byte  (result_byte),
        .result_last  (result_last)
    );

endmodule

// ===== rtl/salsa_front.sv =====
// ----------------------------------------------------------------------------
// salsa_front
// Input side: tracks the byte position and tags each byte with its block
// offset, block index and whether it opens a new keystream block.
// ----------------------------------------------------------------------------
module salsa_front
    import salsa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         data_valid,
    output logic         data_ready,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    input  logic         q_full,
    output logic         q_push,
    output queue_entry_t q_entry
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;

    assign data_ready = !q_full;
    assign q_push     = data_valid && data_ready;

    always_comb
    begin
        q_entry.data    = data_byte;
        q_entry.last    = last_byte;
        q_entry.offset  = pos_reg[OFS_W-1:0];
        q_entry.blk_idx = pos_reg[POS_W-1:OFS_W];
        q_entry.new_blk = (pos_reg[OFS_W-1:0] == '0);
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (q_push)
        begin
            pos_next = last_byte ? '0 : pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

// ===== rtl/salsa_queue.sv =====
// ----------------------------------------------------------------------------
// salsa_queue
// Short FIFO of tagged bytes between the front and back parts.
// ----------------------------------------------------------------------------
module salsa_queue
    import salsa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  queue_entry_t push_entry,
    input  logic         pop,
    output queue_entry_t head,
    output logic         full,
    output logic         empty
);

    queue_entry_t      entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/salsa_core.sv =====
// ----------------------------------------------------------------------------
// salsa_core
// Iterative Salsa20 block function: one quarter-round line of all four
// quarter rounds per cycle, then the feed-forward add of the input words.
// ----------------------------------------------------------------------------
module salsa_core
    import salsa_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  key_t        key,
    input  logic [63:0] nonce,
    input  core_req_t   req,
    output logic        done,
    output word_array_t ks_words
);

    localparam int RND_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

    typedef enum logic [2:0] {
        C_IDLE  = 3'b001,
        C_ROUND = 3'b010,
        C_FINAL = 3'b100
    } core_state_t;

    core_state_t      state_reg;
    core_state_t      state_next;
    logic [1:0]       step_reg;
    logic [1:0]       step_next;
    logic             half_reg;
    logic             half_next;
    logic [RND_W-1:0] round_reg;
    logic [RND_W-1:0] round_next;
    logic [BLK_W-1:0] blk_reg;
    word_array_t      w_reg;
    word_array_t      w_round;
    word_array_t      w_final;
    word_array_t      init_start;
    word_array_t      init_cur;

    assign init_start = make_init(key, nonce, req.blk_idx);
    assign init_cur   = make_init(key, nonce, blk_reg);
    assign done       = (state_reg == C_FINAL);
    assign ks_words   = w_reg;

    always_comb
    begin
        logic [3:0]  ix;
        logic [3:0]  iy;
        logic [3:0]  it;
        logic [31:0] sum;
        w_round = w_reg;
        for (int q = 0; q < 4; q++)
        begin
            ix  = QR_IDX[half_reg][q][step_reg];
            iy  = QR_IDX[half_reg][q][step_reg - 2'd1];
            it  = QR_IDX[half_reg][q][step_reg + 2'd1];
            sum = w_reg[ix] + w_reg[iy];
            w_round[it] = w_reg[it] ^ rotl_step(sum, step_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < WORDS; i++)
        begin
            w_final[i] = w_reg[i] + init_cur[i];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        half_next  = half_reg;
        round_next = round_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (req.start)
                begin
                    state_next = C_ROUND;
                    step_next  = '0;
                    half_next  = 1'b0;
                    round_next = '0;
                end
            end
            C_ROUND:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    half_next = !half_reg;
                    if (half_reg)
                    begin
                        if (round_reg == RND_W'(DOUBLE_ROUNDS - 1))
                        begin
                            state_next = C_FINAL;
                        end
                        else
                        begin
                            round_next = round_reg + RND_W'(1);
                        end
                    end
                end
            end
            C_FINAL:
            begin
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            step_reg  <= '0;
            half_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            half_reg  <= half_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && req.start)
        begin
            w_reg   <= init_start;
            blk_reg <= req.blk_idx;
        end
        else if (state_reg == C_ROUND)
        begin
            w_reg <= w_round;
        end
        else if (state_reg == C_FINAL)
        begin
            w_reg <= w_final;
        end
    end

endmodule

// ===== rtl/salsa_back.sv =====
// ----------------------------------------------------------------------------
// salsa_back
// Output side: pulls tagged bytes from the queue, has the core build a new
// keystream block at each block start, XORs the keystream byte and holds
// the result in an output register.
// ----------------------------------------------------------------------------
module salsa_back
    import salsa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  queue_entry_t head,
    input  logic         q_empty,
    output logic         q_pop,
    output core_req_t    req,
    input  logic         core_done,
    input  word_array_t  ks_words,
    output logic         result_valid,
    input  logic         result_ready,
    output logic [7:0]   result_byte,
    output logic         result_last
);

    typedef enum logic [1:0] {
        B_RUN = 2'b01,
        B_GEN = 2'b10
    } back_state_t;

    back_state_t state_reg;
    back_state_t state_next;
    logic        blk_ready_reg;
    logic        blk_ready_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic [31:0] ks_word;
    logic [7:0]  ks_byte;
    logic        out_free;

    assign out_free = !out_valid_reg || result_ready;
    assign ks_word  = ks_words[head.offset[OFS_W-1:2]];
    assign ks_byte  = ks_word[{head.offset[1:0], 3'b000} +: 8];

    assign q_pop = (state_reg == B_RUN) && !q_empty && out_free
                   && (!head.new_blk || blk_ready_reg);

    assign req.start   = (state_reg == B_RUN) && !q_empty && head.new_blk
                         && !blk_ready_reg;
    assign req.blk_idx = head.blk_idx;

    assign result_valid = out_valid_reg;
    assign result_byte  = out_byte_reg;
    assign result_last  = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        blk_ready_next = blk_ready_reg;
        unique case (state_reg)
            B_RUN:
            begin
                if (req.start)
                begin
                    state_next = B_GEN;
                end
                else if (q_pop && head.new_blk)
                begin
                    blk_ready_next = 1'b0;
                end
            end
            B_GEN:
            begin
                if (core_done)
                begin
                    state_next     = B_RUN;
                    blk_ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = B_RUN;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_RUN;
            blk_ready_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            blk_ready_reg <= blk_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_byte_reg <= head.data ^ ks_byte;
            out_last_reg <= head.last;
        end
    end

endmodule

// ===== rtl/salsa_checker.sv =====
// ----------------------------------------------------------------------------
// salsa_checker
// Port-level checks of the Salsa20 stream XOR unit, bound to the top level.
// ----------------------------------------------------------------------------
module salsa_checker
    import salsa_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [DATA_W-1:0] pwdata,
    input logic [DATA_W-1:0] prdata,
    input logic              pready,
    input logic              data_valid,
    input logic              data_ready,
    input logic              result_valid,
    input logic              result_ready,
    input logic [7:0]        result_byte,
    input logic              result_last
);

    localparam int CNT_W = 4;

    logic [CNT_W-1:0] open_reg;
    logic [CNT_W-1:0] open_next;
    logic             in_done;
    logic             out_done;
    logic             reg_write;

    assign in_done   = data_valid && data_ready;
    assign out_done  = result_valid && result_ready;
    assign reg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        open_next = open_reg;
        if (in_done && !out_done)
        begin
            open_next = open_reg + CNT_W'(1);
        end
        else if (out_done && !in_done)
        begin
            open_next = open_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_done |-> open_reg != '0)
        else $error("result transaction without a pending input byte");

    a_bounded_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg <= CNT_W'(QUEUE_DEPTH + 1))
        else $error("more bytes in flight than queue and output register hold");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_byte) && $stable(result_last))
        else $error("stalled result changed or dropped");

    a_reg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        reg_write && (paddr[ADDR_W-1:3] < 3'(REG_COUNT)) |=>
            (paddr != $past(paddr)) || (prdata == $past(pwdata)))
        else $error("register readback differs from written value");

endmodule

bind salsa20_stream_xor_unit salsa_checker u_checker (.*);
